// ===== design/assert_macros.svh =====
// shared assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define MFE_CHECK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication built on the plain check
`define MFE_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    `MFE_CHECK(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== design/mfe_pkg.sv =====
package mfe_pkg;

    localparam int MAX_CANDIDATES = 64;
    localparam int NODE_BITS      = 10;
    localparam int FRAC_BITS      = 16;
    localparam int VALUE_BITS     = 24;
    localparam int CFG_BITS       = 7;
    localparam int RANK_BITS      = 6;

    localparam logic [CFG_BITS-1:0]  NB_RESET = CFG_BITS'(16);
    localparam logic [FRAC_BITS-1:0] HALF_VAL = FRAC_BITS'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [NODE_BITS-1:0] node_first;
        logic [NODE_BITS-1:0] node_second;
        logic [FRAC_BITS-1:0] frac;
    } mfe_entry_t;

    // handed from one insert cell to the next
    typedef struct packed {
        logic       valid;
        logic       ins;
        mfe_entry_t entry;
    } mfe_link_t;

    // handed from one output cell to the one ahead of it
    typedef struct packed {
        logic       valid;
        mfe_entry_t entry;
    } mfe_slot_t;

    function automatic logic [FRAC_BITS-1:0] score_of(input logic [FRAC_BITS-1:0] frac);
        logic [FRAC_BITS-1:0] s;
        if (frac >= HALF_VAL)
        begin
            s = frac - HALF_VAL;
        end
        else
        begin
            s = HALF_VAL - frac;
        end
        return s;
    endfunction

endpackage

// ===== design/mfe_if.sv =====
interface mfe_edge_if;
    import mfe_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [NODE_BITS-1:0]  node_first;
    logic [NODE_BITS-1:0]  node_second;
    logic [VALUE_BITS-1:0] edge_value;
    logic                  last_edge;

    modport source (output valid, node_first, node_second, edge_value, last_edge,
                    input ready);
    modport sink   (input valid, node_first, node_second, edge_value, last_edge,
                    output ready);
endinterface

interface mfe_result_if;
    import mfe_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [NODE_BITS-1:0] out_first;
    logic [NODE_BITS-1:0] out_second;
    logic [FRAC_BITS-1:0] frac_part;
    logic [RANK_BITS-1:0] rank;
    logic                 last_result;

    modport source (output valid, out_first, out_second, frac_part, rank, last_result,
                    input ready);
    modport sink   (input valid, out_first, out_second, frac_part, rank, last_result,
                    output ready);
endinterface

interface mfe_cfg_if;
    import mfe_pkg::*;

    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] nb_candidates;

    modport source (output valid, nb_candidates, input ready);
    modport sink   (input valid, nb_candidates, output ready);
endinterface

// ===== design/mfe_ins_cell.sv =====
module mfe_ins_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              write_en,
    input  logic                              clear,
    input  mfe_pkg::mfe_entry_t               new_entry,
    input  logic [mfe_pkg::FRAC_BITS-1:0]     new_score,
    input  mfe_pkg::mfe_link_t                prev_link,
    output mfe_pkg::mfe_link_t                link,
    output mfe_pkg::mfe_entry_t               entry_next,
    output logic                              valid_next
);
    import mfe_pkg::*;

    mfe_entry_t entry_reg;
    logic       valid_reg;
    logic       ins;

    // new word lands at or before this cell; ties keep the older word ahead
    assign ins = !valid_reg || (new_score < score_of(entry_reg.frac));

    assign link.valid = valid_reg;
    assign link.ins   = ins;
    assign link.entry = entry_reg;

    always_comb
    begin
        if (prev_link.ins)
        begin
            entry_next = prev_link.entry;
            valid_next = prev_link.valid;
        end
        else if (ins)
        begin
            entry_next = new_entry;
            valid_next = 1'b1;
        end
        else
        begin
            entry_next = entry_reg;
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (write_en)
        begin
            valid_reg <= clear ? 1'b0 : valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== design/mfe_out_cell.sv =====
module mfe_out_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                shift,
    input  mfe_pkg::mfe_slot_t  load_slot,
    input  mfe_pkg::mfe_slot_t  behind_slot,
    output mfe_pkg::mfe_slot_t  slot
);
    import mfe_pkg::*;

    logic       valid_reg;
    mfe_entry_t entry_reg;

    assign slot.valid = valid_reg;
    assign slot.entry = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= load_slot.valid;
        end
        else if (shift)
        begin
            valid_reg <= behind_slot.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= load_slot.entry;
        end
        else if (shift)
        begin
            entry_reg <= behind_slot.entry;
        end
    end

endmodule

// ===== design/most_fractional_edge_top_k.sv =====
// Streaming top-k selector: keeps the edges whose fractional value lies closest
// to one half. One edge word is taken per cycle; a row of MAX_CANDIDATES insert
// cells compares the new score against every kept entry in parallel and shifts
// the tail one cell down in that same cycle. On the word flagged last_edge the
// sorted list (that edge included) is copied into a second row of output cells
// and the insert row is cleared, so the next batch streams in at once. The
// output row then presents one result per cycle unless stalled, nb_candidates
// of them at most (0 counts as 1, more than MAX_CANDIDATES counts as
// MAX_CANDIDATES). A last_edge word arriving while the previous batch is still
// being read out waits until the output row has drained; every other word is
// accepted at full rate. No clearing pass after reset.
module most_fractional_edge_top_k (
    input  logic          clk,
    input  logic          rst_n,
    mfe_edge_if.sink      edges,
    mfe_result_if.source  results,
    mfe_cfg_if.sink       cfg
);
    import mfe_pkg::*;

    // configuration
    logic [CFG_BITS-1:0] nb_candidates_reg;
    logic [CFG_BITS-1:0] limit;

    // handshake and control
    logic in_fire;
    logic batch_end;
    logic out_fire;

    // new word as presented to the insert row
    mfe_entry_t           new_entry;
    logic [FRAC_BITS-1:0] new_score;

    // insert row links; index 0 is the fixed head that never takes the word
    mfe_link_t  ins_link   [MAX_CANDIDATES+1];
    mfe_entry_t entry_next [MAX_CANDIDATES];
    logic       valid_next [MAX_CANDIDATES];

    // output row; the extra slot at the tail is always empty
    mfe_slot_t out_slot  [MAX_CANDIDATES+1];
    mfe_slot_t load_slot [MAX_CANDIDATES];

    logic [RANK_BITS-1:0] rank_reg;
    logic [RANK_BITS-1:0] rank_next;

    // config register: written whenever offered
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_candidates_reg <= NB_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            nb_candidates_reg <= cfg.nb_candidates;
        end
    end

    // clamp the report count to 1..MAX_CANDIDATES
    always_comb
    begin
        if (nb_candidates_reg == '0)
        begin
            limit = CFG_BITS'(1);
        end
        else if (nb_candidates_reg > CFG_BITS'(MAX_CANDIDATES))
        begin
            limit = CFG_BITS'(MAX_CANDIDATES);
        end
        else
        begin
            limit = nb_candidates_reg;
        end
    end

    // a closing word needs the output row free; other words always go in
    assign edges.ready = !(edges.last_edge && out_slot[0].valid);
    assign in_fire     = edges.valid && edges.ready;
    assign batch_end   = in_fire && edges.last_edge;
    assign out_fire    = results.valid && results.ready;

    assign new_entry.node_first  = edges.node_first;
    assign new_entry.node_second = edges.node_second;
    assign new_entry.frac        = edges.edge_value[FRAC_BITS-1:0];
    assign new_score             = score_of(new_entry.frac);

    assign ins_link[0].valid = 1'b1;
    assign ins_link[0].ins   = 1'b0;
    assign ins_link[0].entry = new_entry;

    assign out_slot[MAX_CANDIDATES].valid = 1'b0;
    assign out_slot[MAX_CANDIDATES].entry = new_entry;

    genvar i;
    generate
        for (i = 0; i < MAX_CANDIDATES; i++)
        begin : g_cell
            mfe_ins_cell u_ins (
                .clk        (clk),
                .rst_n      (rst_n),
                .write_en   (in_fire),
                .clear      (batch_end),
                .new_entry  (new_entry),
                .new_score  (new_score),
                .prev_link  (ins_link[i]),
                .link       (ins_link[i+1]),
                .entry_next (entry_next[i]),
                .valid_next (valid_next[i])
            );

            // post-insert list, cut at the report count
            assign load_slot[i].valid = valid_next[i] && (limit > CFG_BITS'(i));
            assign load_slot[i].entry = entry_next[i];

            mfe_out_cell u_out (
                .clk         (clk),
                .rst_n       (rst_n),
                .load        (batch_end),
                .shift       (out_fire),
                .load_slot   (load_slot[i]),
                .behind_slot (out_slot[i+1]),
                .slot        (out_slot[i])
            );
        end
    endgenerate

    // rank restarts with every batch
    always_comb
    begin
        if (batch_end)
        begin
            rank_next = '0;
        end
        else if (out_fire)
        begin
            rank_next = rank_reg + RANK_BITS'(1);
        end
        else
        begin
            rank_next = rank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

    // head of the output row is the result register
    assign results.valid       = out_slot[0].valid;
    assign results.out_first   = out_slot[0].entry.node_first;
    assign results.out_second  = out_slot[0].entry.node_second;
    assign results.frac_part   = out_slot[0].entry.frac;
    assign results.rank        = rank_reg;
    assign results.last_result = !out_slot[1].valid;

endmodule

// ===== design/mfe_checker.sv =====
`include "assert_macros.svh"

module mfe_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          in_last,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mfe_pkg::RANK_BITS-1:0] out_rank,
    input logic                          out_last
);
    import mfe_pkg::*;

    logic in_fire;
    logic out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // a stalled result word stays valid with its rank and last flag unchanged
    `MFE_CHECK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_rank) && $stable(out_last), "result word changed while stalled")

    // a closed batch always reports at least one result, starting at rank zero
    `MFE_CHECK_NEXT(a_batch_reports, clk, rst_n, in_fire && in_last, out_valid && out_rank == '0, "closed batch gave no first result")

    // ranks count up by one inside a batch
    `MFE_CHECK_NEXT(a_rank_step, clk, rst_n, out_fire && !out_last, out_valid && out_rank == RANK_BITS'($past(out_rank) + 1'b1), "rank did not step by one")

    // nothing follows the final result of a batch in the next cycle
    `MFE_CHECK_NEXT(a_batch_gap, clk, rst_n, out_fire && out_last, !out_valid, "result after final word of batch")

endmodule

bind most_fractional_edge_top_k mfe_checker u_mfe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (edges.valid),
    .in_ready  (edges.ready),
    .in_last   (edges.last_edge),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_rank  (results.rank),
    .out_last  (results.last_result)
);

// ===== tb/mfe_top_k_checker.sv =====
module mfe_top_k_checker
    import mfe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    mfe_edge_if    edges,
    mfe_result_if  results,
    mfe_cfg_if     cfg,
    output int     fail_count,
    output int     pending
);

    // one reported edge as the block should present it
    typedef struct packed {
        logic [NODE_BITS-1:0] first;
        logic [NODE_BITS-1:0] second;
        logic [FRAC_BITS-1:0] frac;
        logic [RANK_BITS-1:0] rank;
        logic                 last;
    } pick_t;

    localparam logic [FRAC_BITS-1:0] ONE_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    mfe_entry_t          kept[MAX_CANDIDATES];
    int                  kept_count;
    logic [CFG_BITS-1:0] limit_reg;
    pick_t               expected_picks[$];

    function automatic logic [FRAC_BITS-1:0] distance_from_half(input logic [FRAC_BITS-1:0] f);
        return (f >= ONE_HALF) ? f - ONE_HALF : ONE_HALF - f;
    endfunction

    // sorted insert, equal distances keep arrival order
    function automatic void keep_edge(input mfe_entry_t e);
        logic [FRAC_BITS-1:0] d;
        int pos;
        int k;
        d = distance_from_half(e.frac);
        pos = 0;
        while (pos < kept_count && distance_from_half(kept[pos].frac) <= d)
            pos++;
        if (pos >= MAX_CANDIDATES)
            return;
        k = (kept_count < MAX_CANDIDATES) ? kept_count : MAX_CANDIDATES - 1;
        while (k > pos)
        begin
            kept[k] = kept[k - 1];
            k--;
        end
        kept[pos] = e;
        if (kept_count < MAX_CANDIDATES)
            kept_count++;
    endfunction

    function automatic void release_batch();
        int    lim;
        int    n;
        pick_t p;
        if (limit_reg == 0)
            lim = 1;
        else if (limit_reg > MAX_CANDIDATES)
            lim = MAX_CANDIDATES;
        else
            lim = limit_reg;
        n = (kept_count < lim) ? kept_count : lim;
        for (int i = 0; i < n; i++)
        begin
            p.first  = kept[i].node_first;
            p.second = kept[i].node_second;
            p.frac   = kept[i].frac;
            p.rank   = RANK_BITS'(i);
            p.last   = (i == n - 1);
            expected_picks.push_back(p);
        end
        kept_count = 0;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        if (fail_count <= 40)
            $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    endtask

    always @(posedge clk)
    begin
        pick_t      want;
        mfe_entry_t e;
        if (!rst_n)
        begin
            kept_count = 0;
            limit_reg  = NB_RESET;
            expected_picks.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // results first: a word from this edge's batch cannot show up yet
            if (results.valid && results.ready)
            begin
                if (expected_picks.size() == 0)
                begin
                    report_mismatch("unexpected result word, rank", results.rank, -1);
                end
                else
                begin
                    want = expected_picks.pop_front();
                    if (results.out_first !== want.first)
                        report_mismatch("out_first", results.out_first, want.first);
                    if (results.out_second !== want.second)
                        report_mismatch("out_second", results.out_second, want.second);
                    if (results.frac_part !== want.frac)
                        report_mismatch("frac_part", results.frac_part, want.frac);
                    if (results.rank !== want.rank)
                        report_mismatch("rank", results.rank, want.rank);
                    if (results.last_result !== want.last)
                        report_mismatch("last_result", results.last_result, want.last);
                end
            end
            if (cfg.valid && cfg.ready)
                limit_reg = cfg.nb_candidates;
            if (edges.valid && edges.ready)
            begin
                e.node_first  = edges.node_first;
                e.node_second = edges.node_second;
                e.frac        = edges.edge_value[FRAC_BITS-1:0];
                keep_edge(e);
                if (edges.last_edge)
                    release_batch();
            end
            pending = expected_picks.size();
        end
    end

endmodule

// ===== tb/tb_most_fractional_edge_top_k.sv =====
module tb_most_fractional_edge_top_k;
    import mfe_pkg::*;

    localparam int TOTAL_EDGES  = 220;     // directed words included
    localparam int HOLD_CYCLES  = 250;     // long receiver hold-off
    localparam int SETTLE       = 6;       // idle cycles between test phases
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   edges_sent;
    logic stall_request;
    int   hold_count;
    logic hold_done;

    mfe_edge_if   edge_bus();
    mfe_result_if pick_bus();
    mfe_cfg_if    cfg_bus();

    most_fractional_edge_top_k u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .edges   (edge_bus),
        .results (pick_bus),
        .cfg     (cfg_bus)
    );

    // watches all three channels, predicts the reported edges and compares
    mfe_top_k_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .edges      (edge_bus),
        .results    (pick_bus),
        .cfg        (cfg_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // watchdog: a hung block or a lost result word ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result receiver: random backpressure, one long hold-off once the random
    // part starts, and a calm window with ready held high
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pick_bus.ready <= 1'b0;
            hold_count     <= 0;
            hold_done      <= 1'b0;
        end
        else if (stall_request && !hold_done)
        begin
            // the block keeps one batch in its output row, so the next
            // last_edge word has to stall the edge channel during this
            pick_bus.ready <= 1'b0;
            hold_count     <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
        else
        begin
            pick_bus.ready <= (cycle_count >= 700 && cycle_count < 1300)
                              || ($urandom_range(99) >= 14);
        end
    end

    // offer one edge word and return at the edge where it is taken;
    // ready is looked at on the falling edge so the sample is settled
    task automatic send_edge(input logic [NODE_BITS-1:0] a, input logic [NODE_BITS-1:0] b,
                             input logic [VALUE_BITS-1:0] v, input logic last);
        bit calm;
        calm = (edges_sent >= 100 && edges_sent < 160);
        if (!calm && $urandom_range(99) < 14)
        begin
            edge_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        edge_bus.valid       <= 1'b1;
        edge_bus.node_first  <= a;
        edge_bus.node_second <= b;
        edge_bus.edge_value  <= v;
        edge_bus.last_edge   <= last;
        @(negedge clk);
        while (!edge_bus.ready)
            @(negedge clk);
        @(posedge clk);
        edges_sent++;
    endtask

    // stop offering and wait until every expected result word has come,
    // then a few idle cycles
    task automatic wait_for_results();
        edge_bus.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_BITS-1:0] v);
        cfg_bus.valid         <= 1'b1;
        cfg_bus.nb_candidates <= v;
        @(negedge clk);
        while (!cfg_bus.ready)
            @(negedge clk);
        @(posedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // edge value with a fraction aimed at interesting distances from one half
    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [FRAC_BITS-1:0] f;
        logic [7:0]           whole;
        whole = 8'($urandom);
        case ($urandom_range(3))
            0:
                f = FRAC_BITS'($urandom);
            1:
            begin
                // close to one half, either side
                if ($urandom_range(1))
                    f = 16'h8000 + 16'($urandom_range(0, 255));
                else
                    f = 16'h8000 - 16'($urandom_range(0, 255));
            end
            2:
            begin
                // small pool so equal distances show up often
                case ($urandom_range(4))
                    0: f = 16'h8000;
                    1: f = 16'h7000;
                    2: f = 16'h9000;
                    3: f = 16'h0000;
                    default: f = 16'hFFFF;
                endcase
            end
            default:
                f = FRAC_BITS'($urandom);
        endcase
        return {whole, f};
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_limit();
        case ($urandom_range(5))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd64;
            3: return 7'd127;
            4: return CFG_BITS'($urandom_range(1, 20));
            default: return CFG_BITS'($urandom_range(0, 127));
        endcase
    endfunction

    initial
    begin
        int batch_no;
        int batch_len;
        rst_n                 <= 1'b0;
        edge_bus.valid        <= 1'b0;
        edge_bus.node_first   <= '0;
        edge_bus.node_second  <= '0;
        edge_bus.edge_value   <= '0;
        edge_bus.last_edge    <= 1'b0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.nb_candidates <= '0;
        stall_request         <= 1'b0;
        edges_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit of 16: distance extremes, ties on both sides of one
        // half, integer part ignored, node extremes
        send_edge(10'd0, 10'd1023, 24'h008000, 1'b0);
        send_edge(10'd1023, 10'd0, 24'hFF0000, 1'b0);
        send_edge(10'd512, 10'd511, 24'hFFFFFF, 1'b0);
        send_edge(10'd1, 10'd2, 24'h017000, 1'b0);
        send_edge(10'd3, 10'd4, 24'h009000, 1'b0);
        send_edge(10'd5, 10'd6, 24'h7F8000, 1'b1);
        wait_for_results();

        // limit zero reports one edge
        write_limit(7'd0);
        send_edge(10'd1023, 10'd1023, 24'hAAAAAA, 1'b0);
        send_edge(10'd0, 10'd0, 24'h000001, 1'b1);
        wait_for_results();

        // top of the register range clamps to the list size
        write_limit(7'd127);
        send_edge(10'd100, 10'd200, 24'h004000, 1'b0);
        send_edge(10'd300, 10'd400, 24'h00C000, 1'b0);
        send_edge(10'd500, 10'd600, 24'h008001, 1'b1);
        wait_for_results();

        // limit changed in the middle of a batch: the value at the last word counts
        write_limit(7'd2);
        send_edge(10'd7, 10'd8, 24'h123456, 1'b0);
        send_edge(10'd9, 10'd10, 24'h00ABCD, 1'b0);
        send_edge(10'd11, 10'd12, 24'h005555, 1'b0);
        wait_for_results();
        write_limit(7'd64);
        send_edge(10'd13, 10'd14, 24'h0F7FFF, 1'b1);
        wait_for_results();

        // just above the list size, single-word batch
        write_limit(7'd65);
        send_edge(10'd777, 10'd888, 24'h3C2A5F, 1'b1);
        wait_for_results();
        write_limit(7'd16);

        // random batches; the receiver hold-off starts with the first of them
        stall_request <= 1'b1;
        batch_no = 0;
        while (edges_sent < TOTAL_EDGES)
        begin
            // keep the first batches short and back to back so the hold-off
            // backs up the output row and stalls the edge channel
            if (batch_no >= 4)
            begin
                if ($urandom_range(3) == 0)
                begin
                    wait_for_results();
                    write_limit(pick_limit());
                end
                else if ($urandom_range(5) == 0)
                begin
                    wait_for_results();
                end
            end
            // a few batches overflow the list so edges are dropped
            if (batch_no >= 4 && $urandom_range(7) == 0)
                batch_len = $urandom_range(65, 90);
            else
                batch_len = $urandom_range(1, 12);
            if (batch_len > TOTAL_EDGES - edges_sent)
                batch_len = TOTAL_EDGES - edges_sent;
            for (int i = 0; i < batch_len; i++)
            begin
                send_edge(NODE_BITS'($urandom), NODE_BITS'($urandom), pick_value(),
                          i == batch_len - 1);
            end
            batch_no++;
        end

        // all words taken: drain, settle, then the verdict
        wait_for_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/mfe_pkg.sv
design/mfe_if.sv
design/mfe_ins_cell.sv
design/mfe_out_cell.sv
design/most_fractional_edge_top_k.sv
design/mfe_checker.sv
tb/mfe_top_k_checker.sv
tb/tb_most_fractional_edge_top_k.sv
